// ===== src/ffla_pkg.sv =====
// Shared types and constants for the frame free list allocator.
// Depends on nothing; every other source file uses it, the RTL by scoped names and the testbench by import.
`default_nettype none

package ffla_pkg;

	// Frame table size and derived widths
	localparam int NUM_FRAMES = 4096;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int CNT_W      = FRAME_W + 1;

	// Fixed field widths of the ports
	localparam int FIELD_W    = 12;
	localparam int CFG_W      = 12;
	localparam int FUNC_W     = 2;
	localparam int CFG_IDX_W  = 1;

	// Width for config arithmetic (start + count, NUM_FRAMES - count)
	localparam int SUM_W = ((CFG_W > FRAME_W) ? CFG_W : FRAME_W) + 2;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd3;

	// Result status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_NO_FREE = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIST_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_RSVD   = 1'd1;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FIELD_W-1:0] frame_index;
		logic               reserved_flag;
	} req_word_t;

	typedef struct packed {
		logic [FIELD_W-1:0] granted_frame;
		logic               status;
	} rsp_word_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic cap;         // capture request word, preset result
		logic rd_link;     // read tables at the link just read (walk)
		logic pop;         // pop head frame
		logic grant;       // write reserved flag of granted frame
		logic res_grant;   // result: granted head frame
		logic res_nofree;  // result: no free frames
		logic free;        // append frame at tail
		logic mark;        // set reserved bit of frame
		logic clr_step;    // clear one reserved bit (after reset)
		logic rsv_step;    // set one top reserved bit (init)
		logic list_init;   // load head/tail/empty from config
		logic link_step;   // write one init link
		logic rsp_load;    // move result into output register
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic [FUNC_W-1:0] req_func;
		logic list_empty;
		logic head_rsv;
		logic head_is_tail;
		logic cnt_last;
		logic rsv_none;
		logic list_none;
		logic link_none;
		logic link_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/ffla_dp.sv =====
// Datapath of the frame free list allocator: config registers, list pointers,
// walk counter, link and reserved-bit tables, result and output registers.
// Depends on ffla_pkg.
`default_nettype none

module ffla_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire ffla_pkg::req_word_t       req,
	input  wire ffla_pkg::cmd_t            cmd,
	input  wire                            cfg_we,
	input  wire [ffla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [ffla_pkg::CFG_W-1:0]      cfg_data,
	output ffla_pkg::sts_t                 sts,
	output ffla_pkg::rsp_word_t            rsp
);

	localparam int FW = ffla_pkg::FRAME_W;
	localparam int CW = ffla_pkg::CNT_W;
	localparam int SW = ffla_pkg::SUM_W;

	logic [ffla_pkg::CFG_W-1:0] start_q;
	logic [ffla_pkg::CFG_W-1:0] top_q;
	logic [FW-1:0]              head_q;
	logic [FW-1:0]              tail_q;
	logic                       empty_q;
	logic [CW-1:0]              cnt_q;
	logic [FW-1:0]              fidx_q;
	logic                       rflag_q;
	ffla_pkg::rsp_word_t        res_q;
	ffla_pkg::rsp_word_t        rsp_q;

	logic [FW-1:0] link_mem [ffla_pkg::NUM_FRAMES];
	logic          rsv_mem  [ffla_pkg::NUM_FRAMES];
	logic [FW-1:0] link_rd_q;
	logic          rsv_rd_q;

	logic [SW-1:0] top_w;
	logic [SW-1:0] top_sat;
	logic [SW-1:0] base_w;
	logic [SW-1:0] last_w;
	logic [SW-1:0] start_w;
	logic          list_none;
	logic [FW-1:0] cnt_idx;
	logic [FW-1:0] rd_addr;

	logic          rsv_we;
	logic [FW-1:0] rsv_wa;
	logic          rsv_wd;
	logic          link_we;
	logic [FW-1:0] link_wa;
	logic [FW-1:0] link_wd;

	// Init geometry from config: top count saturates at the table size
	always_comb begin
		top_w     = SW'(top_q);
		top_sat   = (top_w > SW'(ffla_pkg::NUM_FRAMES)) ? SW'(ffla_pkg::NUM_FRAMES) : top_w;
		base_w    = SW'(ffla_pkg::NUM_FRAMES) - top_sat;
		last_w    = SW'(ffla_pkg::NUM_FRAMES - 1) - top_sat;
		start_w   = SW'(start_q);
		list_none = (start_w + top_sat) >= SW'(ffla_pkg::NUM_FRAMES);
	end

	assign cnt_idx = cnt_q[FW-1:0];
	assign rd_addr = cmd.rd_link ? link_rd_q : head_q;

	// Status to controller
	always_comb begin
		sts.req_func     = req.func;
		sts.list_empty   = empty_q;
		sts.head_rsv     = rsv_rd_q;
		sts.head_is_tail = (head_q == tail_q);
		sts.cnt_last     = (cnt_q == CW'(ffla_pkg::NUM_FRAMES - 1));
		sts.rsv_none     = (top_sat == '0);
		sts.list_none    = list_none;
		sts.link_none    = (start_w == last_w);
		sts.link_last    = ((cnt_idx + FW'(1)) == tail_q);
	end

	// Reserved-bit table write port
	always_comb begin
		rsv_we = 1'b0;
		rsv_wa = cnt_idx;
		rsv_wd = 1'b0;
		if (cmd.clr_step) begin
			rsv_we = 1'b1;
		end else if (cmd.rsv_step) begin
			rsv_we = 1'b1;
			rsv_wd = 1'b1;
		end else if (cmd.mark) begin
			rsv_we = 1'b1;
			rsv_wa = fidx_q;
			rsv_wd = 1'b1;
		end else if (cmd.grant) begin
			rsv_we = 1'b1;
			rsv_wa = head_q;
			rsv_wd = rflag_q;
		end
	end

	// Link table write port
	always_comb begin
		link_we = 1'b0;
		link_wa = cnt_idx;
		link_wd = cnt_idx + FW'(1);
		if (cmd.free) begin
			link_we = 1'b1;
			link_wa = empty_q ? fidx_q : tail_q;
			link_wd = fidx_q;
		end else if (cmd.link_step) begin
			link_we = 1'b1;
		end
	end

	// Tables: one write and one registered read each
	always_ff @(posedge clk) begin
		if (rsv_we) begin
			rsv_mem[rsv_wa] <= rsv_wd;
		end
		rsv_rd_q <= rsv_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd_q <= link_mem[rd_addr];
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			top_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ffla_pkg::REG_LIST_START: start_q <= cfg_data;
				ffla_pkg::REG_TOP_RSVD:   top_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// List pointers and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			if (cmd.cap) begin
				cnt_q <= (req.func == ffla_pkg::FUNC_INIT) ? base_w[CW-1:0] : '0;
			end
			if (cmd.clr_step || cmd.rsv_step || cmd.link_step || cmd.pop) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.free) begin
				tail_q  <= fidx_q;
				empty_q <= 1'b0;
				if (empty_q) begin
					head_q <= fidx_q;
				end
			end
			if (cmd.list_init) begin
				cnt_q <= start_w[CW-1:0];
				if (list_none) begin
					empty_q <= 1'b1;
				end else begin
					head_q  <= start_w[FW-1:0];
					tail_q  <= last_w[FW-1:0];
					empty_q <= 1'b0;
				end
			end
			if (cmd.pop) begin
				if (head_q == tail_q) begin
					empty_q <= 1'b1;
				end else begin
					head_q <= link_rd_q;
				end
			end
		end
	end

	// Request capture, result and output word
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			fidx_q              <= req.frame_index[FW-1:0];
			rflag_q             <= req.reserved_flag;
			res_q.granted_frame <= '0;
			res_q.status        <= (req.func == ffla_pkg::FUNC_ALLOC && empty_q) ?
				ffla_pkg::ST_NO_FREE : ffla_pkg::ST_OK;
		end
		if (cmd.res_grant) begin
			res_q.granted_frame <= ffla_pkg::FIELD_W'(head_q);
			res_q.status        <= ffla_pkg::ST_OK;
		end
		if (cmd.res_nofree) begin
			res_q.granted_frame <= '0;
			res_q.status        <= ffla_pkg::ST_NO_FREE;
		end
		if (cmd.rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== src/ffla_ctrl.sv =====
// Controller of the frame free list allocator: sequences the clearing pass,
// the allocate walk, free, mark and init, and owns both handshakes.
// Depends on ffla_pkg.
`default_nettype none

module ffla_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	input  wire ffla_pkg::sts_t  sts,
	output ffla_pkg::cmd_t       cmd
);

	localparam logic [3:0] S_CLR       = 4'd0;
	localparam logic [3:0] S_IDLE      = 4'd1;
	localparam logic [3:0] S_CHK       = 4'd2;
	localparam logic [3:0] S_FREE      = 4'd3;
	localparam logic [3:0] S_MARK      = 4'd4;
	localparam logic [3:0] S_INIT_RSV  = 4'd5;
	localparam logic [3:0] S_INIT_LIST = 4'd6;
	localparam logic [3:0] S_INIT_LINK = 4'd7;
	localparam logic [3:0] S_RESP      = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.cnt_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					case (sts.req_func)
						ffla_pkg::FUNC_ALLOC: state_nx = sts.list_empty ? S_RESP : S_CHK;
						ffla_pkg::FUNC_FREE:  state_nx = S_FREE;
						ffla_pkg::FUNC_INIT:  state_nx = sts.rsv_none ? S_INIT_LIST : S_INIT_RSV;
						ffla_pkg::FUNC_MARK:  state_nx = S_MARK;
						default:              state_nx = S_RESP;
					endcase
				end
			end
			// one frame popped per cycle; next head is read meanwhile
			S_CHK: begin
				cmd.rd_link = 1'b1;
				cmd.pop     = 1'b1;
				if (!sts.head_rsv) begin
					cmd.grant     = 1'b1;
					cmd.res_grant = 1'b1;
					state_nx      = S_RESP;
				end else if (sts.head_is_tail || sts.cnt_last) begin
					cmd.res_nofree = 1'b1;
					state_nx       = S_RESP;
				end
			end
			S_FREE: begin
				cmd.free = 1'b1;
				state_nx = S_RESP;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				state_nx = S_RESP;
			end
			S_INIT_RSV: begin
				cmd.rsv_step = 1'b1;
				if (sts.cnt_last) begin
					state_nx = S_INIT_LIST;
				end
			end
			S_INIT_LIST: begin
				cmd.list_init = 1'b1;
				if (sts.list_none || sts.link_none) begin
					state_nx = S_RESP;
				end else begin
					state_nx = S_INIT_LINK;
				end
			end
			S_INIT_LINK: begin
				cmd.link_step = 1'b1;
				if (sts.link_last) begin
					state_nx = S_RESP;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.rsp_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// State and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/frame_free_list_allocator.sv =====
// Top level of the frame free list allocator: controller plus datapath.
// Depends on ffla_pkg, ffla_ctrl and ffla_dp.
//
// Physical frame allocator over a 4096-frame linked FIFO free list, one
// request word in, one response word out. After reset the block runs a
// clearing pass over the reserved-bit table before req_ready first rises;
// register writes are taken during it. Requests are handled one at a time by
// a state machine working on two tables (next link, reserved bit), each with
// one write port and one registered read port. Allocate pops frames from the
// head, dropping reserved frames one per cycle, at most 4096 frames; init sets
// the R reserved top frames and writes the L links, one table entry per cycle.
// The result waits in an output register so the next request can be taken
// while it is held.
`default_nettype none

module frame_free_list_allocator (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_ready,
	input  wire ffla_pkg::req_word_t       req,
	output logic                           rsp_valid,
	input  wire                            rsp_ready,
	output ffla_pkg::rsp_word_t            rsp,
	input  wire                            cfg_we,
	input  wire [ffla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [ffla_pkg::CFG_W-1:0]      cfg_data
);

	ffla_pkg::cmd_t cmd;
	ffla_pkg::sts_t sts;

	ffla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffla_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== src/ffla_checker.sv =====
// Port-level checks for the frame free list allocator, bound to its top.
// Depends on ffla_pkg.
`default_nettype none

module ffla_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      req_valid,
	input wire                      req_ready,
	input wire ffla_pkg::rsp_word_t rsp,
	input wire                      rsp_valid,
	input wire                      rsp_ready
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// A response only for an accepted request; at most two in flight
	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0))
		else $error("response word without pending request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests in flight");

	// One request at a time: busy right after an accept
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while previous one in work");

	// A held response word does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// No-free status carries frame zero
	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ffla_pkg::ST_NO_FREE) |-> (rsp.granted_frame == '0))
		else $error("no-free response with nonzero frame");

endmodule

bind frame_free_list_allocator ffla_checker u_ffla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for frame_free_list_allocator: random request words checked
// against an in-bench shadow of the frame tables. Depends on ffla_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
	import ffla_pkg::*;

	localparam int RANDOM_WORDS = 1900;
	localparam int BASE_LIMIT   = 40000;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 req_valid   = 1'b0;
	logic                 req_ready;
	req_word_t            req         = '0;
	logic                 rsp_valid;
	logic                 rsp_ready   = 1'b0;
	rsp_word_t            rsp;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;

	// Request words waiting to be driven, responses still owed by the block
	req_word_t            req_backlog[$];
	rsp_word_t            due_responses[$];
	// Frames the "software" currently holds, candidates for a clean free
	int                   held_frames[$];

	// Shadow of the allocator state and its registers
	bit [FRAME_W-1:0]     link_shadow [NUM_FRAMES];
	bit                   rsv_shadow  [NUM_FRAMES];
	bit [FRAME_W-1:0]     head_shadow;
	bit [FRAME_W-1:0]     tail_shadow;
	bit                   empty_shadow = 1'b1;
	bit [CFG_W-1:0]       start_shadow;
	bit [CFG_W-1:0]       top_shadow;

	int                   mismatch_count;
	int                   cycle_count;
	int                   work_cycles;
	bit                   steady_run;
	rsp_word_t            oldest_due;

	frame_free_list_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Applies one request word to the shadow state and returns the response it owes.
	// Also adds the table cycles it costs to the run budget.
	function automatic rsp_word_t allocator_outcome(req_word_t w);
		rsp_word_t        r;
		int               walked;
		int               top;
		int               i;
		bit [FRAME_W-1:0] got;
		bit               found;
		r      = '0;
		walked = 0;
		found  = 1'b0;
		case (w.func)
		FUNC_ALLOC: begin
			// pop from the head, dropping reserved frames, at most one full table
			while (walked < NUM_FRAMES && !empty_shadow && !found) begin
				got = head_shadow;
				if (head_shadow == tail_shadow)
					empty_shadow = 1'b1;
				else
					head_shadow = link_shadow[got];
				if (!rsv_shadow[got]) begin
					rsv_shadow[got] = w.reserved_flag;
					r.granted_frame = got;
					found = 1'b1;
					held_frames.push_back(int'(got));
				end
				walked++;
			end
			if (!found)
				r.status = ST_NO_FREE;
			work_cycles += walked;
		end
		FUNC_FREE: begin
			if (int'(w.frame_index) < NUM_FRAMES) begin
				if (empty_shadow) begin
					link_shadow[w.frame_index] = w.frame_index;
					head_shadow  = w.frame_index;
					empty_shadow = 1'b0;
				end else begin
					link_shadow[tail_shadow] = w.frame_index;
				end
				tail_shadow = w.frame_index;
			end
		end
		FUNC_INIT: begin
			top = (int'(top_shadow) > NUM_FRAMES) ? NUM_FRAMES : int'(top_shadow);
			for (i = NUM_FRAMES - top; i < NUM_FRAMES; i++)
				rsv_shadow[i] = 1'b1;
			if (int'(start_shadow) + top >= NUM_FRAMES) begin
				empty_shadow = 1'b1;
			end else begin
				head_shadow = FRAME_W'(start_shadow);
				tail_shadow = FRAME_W'(NUM_FRAMES - 1 - top);
				for (i = int'(start_shadow); i < NUM_FRAMES - 1 - top; i++)
					link_shadow[i] = FRAME_W'(i + 1);
				empty_shadow = 1'b0;
			end
			work_cycles += NUM_FRAMES - int'(start_shadow) + top;
			// everything held before may be relinked now
			held_frames.delete();
		end
		default: begin
			if (int'(w.frame_index) < NUM_FRAMES)
				rsv_shadow[w.frame_index] = 1'b1;
		end
		endcase
		return r;
	endfunction

	// Request driver: valid holds with a fixed word until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				due_responses.push_back(allocator_outcome(req));
				work_cycles += 64;
			end
			if (!req_valid || req_ready) begin
				if (req_backlog.size() != 0 && (steady_run || $urandom_range(99) >= 30)) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare each taken word with the oldest owed one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_responses.size() == 0) begin
					$display("%0t: unexpected response word, frame %0d status %0d", $time,
						rsp.granted_frame, rsp.status);
					mismatch_count++;
				end else begin
					oldest_due = due_responses.pop_front();
					if (rsp.granted_frame !== oldest_due.granted_frame) begin
						$display("%0t: granted_frame expected %0d, got %0d", $time,
							oldest_due.granted_frame, rsp.granted_frame);
						mismatch_count++;
					end
					if (rsp.status !== oldest_due.status) begin
						$display("%0t: status expected %0d, got %0d", $time,
							oldest_due.status, rsp.status);
						mismatch_count++;
					end
				end
			end
			rsp_ready <= steady_run || ($urandom_range(99) >= 30);
		end
	end

	// Watchdog, scaled by the table work predicted so far
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > BASE_LIMIT + 4 * work_cycles) begin
			$display("** frame_free_list_allocator: FAILED **");
			$finish;
		end
	end

	task automatic offer(input logic [FUNC_W-1:0] op, input int frame, input bit flag);
		req_word_t w;
		w.func          = op;
		w.frame_index   = FIELD_W'(frame);
		w.reserved_flag = flag;
		while (req_backlog.size() >= 4)
			@(negedge clk);
		req_backlog.push_back(w);
	endtask

	// Wait until every word is taken and every response is back
	task automatic drain();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || req_valid || due_responses.size() != 0);
	endtask

	// Register writes happen only after every word is taken and every response is back
	task automatic set_config(input int start, input int top);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LIST_START;
		cfg_data  <= CFG_W'(start);
		@(posedge clk);
		cfg_index <= REG_TOP_RSVD;
		cfg_data  <= CFG_W'(top);
		@(posedge clk);
		cfg_we       <= 1'b0;
		start_shadow  = CFG_W'(start);
		top_shadow    = CFG_W'(top);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int random_words;
		int phase;
		int start;
		int top;
		int run_len;
		int words;
		int pick;
		int slot;
		random_words = 0;
		phase        = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, free on empty, reserved frames, skips, corrupt frees
		set_config(4092, 1);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_FREE, 0, 1'b1);
		offer(FUNC_MARK, 4095, 1'b0);
		offer(FUNC_FREE, 4095, 1'b0);
		offer(FUNC_ALLOC, 4095, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_INIT, 0, 1'b1);
		offer(FUNC_MARK, 4093, 1'b1);
		offer(FUNC_ALLOC, 0, 1'b1);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_FREE, 4094, 1'b0);
		offer(FUNC_FREE, 4094, 1'b0);
		offer(FUNC_FREE, 2730, 1'b0);
		offer(FUNC_FREE, 1365, 1'b1);
		offer(FUNC_ALLOC, 0, 1'b1);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b1);
		// start plus count reaches the table size: list stays empty
		set_config(4090, 6);
		offer(FUNC_INIT, 4095, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		// whole table on the list
		set_config(0, 0);
		offer(FUNC_INIT, 0, 1'b0);
		offer(FUNC_MARK, 1, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_FREE, 1, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);

		// Random phases: short lists near the top of the table, mostly clean usage
		while (random_words < RANDOM_WORDS) begin
			top     = ($urandom_range(99) < 10) ? $urandom_range(0, 40) : $urandom_range(0, 4);
			run_len = ($urandom_range(99) < 15) ? $urandom_range(200, 900)
				: $urandom_range(4, 120);
			start   = NUM_FRAMES - top - run_len;
			set_config(start, top);
			steady_run = (phase == 6);
			offer(FUNC_INIT, $urandom, 1'($urandom_range(1)));
			words = $urandom_range(30, 110);
			repeat (words) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					offer(FUNC_ALLOC, $urandom, $urandom_range(99) < 15);
				end else if (pick < 70) begin
					if (held_frames.size() != 0) begin
						slot = $urandom_range(held_frames.size() - 1);
						offer(FUNC_FREE, held_frames[slot], 1'($urandom_range(1)));
						held_frames.delete(slot);
					end else begin
						offer(FUNC_ALLOC, $urandom, 1'b0);
					end
				end else if (pick < 78) begin
					offer(FUNC_MARK, $urandom_range(start, NUM_FRAMES - 1),
						1'($urandom_range(1)));
				end else if (pick < 86) begin
					// noise: free of any frame, listed or not
					offer(FUNC_FREE, $urandom_range(NUM_FRAMES - 1), 1'($urandom_range(1)));
				end else if (pick < 92) begin
					offer(FUNC_MARK, $urandom_range(NUM_FRAMES - 1), 1'($urandom_range(1)));
				end else if (pick < 95) begin
					offer(FUNC_INIT, $urandom, 1'($urandom_range(1)));
				end else begin
					offer(FUNC_ALLOC, $urandom, 1'b0);
				end
			end
			random_words += words + 1;
			phase++;
		end
		steady_run = 1'b0;

		// Register extremes last: these reserve nearly the whole table for good
		set_config(4095, 0);
		offer(FUNC_INIT, 0, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		set_config(0, 4095);
		offer(FUNC_INIT, 4095, 1'b1);
		offer(FUNC_ALLOC, 0, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b0);
		set_config(4095, 4095);
		offer(FUNC_INIT, 0, 1'b0);
		offer(FUNC_ALLOC, 0, 1'b1);

		drain();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** frame_free_list_allocator: PASSED **");
		end else begin
			$display("** frame_free_list_allocator: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/ffla_pkg.sv
src/ffla_dp.sv
src/ffla_ctrl.sv
src/frame_free_list_allocator.sv
src/ffla_checker.sv
tb/testbench.sv
